[rtl/core/ddfan_pkg.sv]
// ----------------------------------------------------------------------------
// ddfan_pkg
// Types and constants for the dust density averaging and fan decision unit.
// ----------------------------------------------------------------------------
`default_nettype none

package ddfan_pkg;

  // group size default
  localparam int SAMPLES_DEF = 5;

  // field widths
  localparam int ADC_W     = 12;
  localparam int TEMP_W    = 8;
  localparam int DENS_W    = 9;
  localparam int CLASS_W   = 3;
  localparam int DUTY_W    = 16;
  localparam int TLIM_W    = 6;
  localparam int DLIM_W    = 9;
  localparam int ADC_MAX   = 4095;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_TEMP_LIMIT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DUST_LIMIT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FAN_RUN_DUTY = 2'd2;

  localparam logic [TLIM_W-1:0] TEMP_LIMIT_RST   = 6'd25;
  localparam logic [DLIM_W-1:0] DUST_LIMIT_RST   = 9'd100;
  localparam logic [DUTY_W-1:0] FAN_RUN_DUTY_RST = 16'd500;

  // density = round_half_up((adc*1122 - 409500) / 4095), clamped to 0..500
  localparam longint unsigned DENS_SCALE  = 64'd1122;
  localparam longint unsigned DENS_DEN    = 64'd4095;
  localparam longint unsigned DENS_OFFSET = 64'd409500;
  localparam int              DENS_MAX    = 500;

  // adc at or below this gives zero, at or above the other gives the maximum
  localparam int DENS_ZERO_ADC = int'(DENS_OFFSET / DENS_SCALE);
  localparam int DENS_SAT_ADC  =
      int'((DENS_OFFSET + 64'(DENS_MAX) * DENS_DEN + DENS_SCALE - 1) / DENS_SCALE);

  // q = floor((2*scale*adc - (2*offset - den)) / (2*den)) by a scaled reciprocal
  localparam int              DENS_SHIFT = 35;
  localparam longint unsigned DENS_DIV2  = 2 * DENS_DEN;
  localparam longint unsigned DENS_RECIP =
      ((64'd1 << DENS_SHIFT) + DENS_DIV2 - 1) / DENS_DIV2;
  localparam longint unsigned DENS_MUL   = 2 * DENS_SCALE * DENS_RECIP;
  localparam longint unsigned DENS_SUB   = (2 * DENS_OFFSET - DENS_DEN) * DENS_RECIP;
  localparam int              DENS_PROD_W = 47;

  // air quality band limits
  localparam logic [DENS_W-1:0] BAND_EXCELLENT_MAX = 9'd35;
  localparam logic [DENS_W-1:0] BAND_GOOD_MAX      = 9'd75;
  localparam logic [DENS_W-1:0] BAND_LIGHT_MAX     = 9'd115;
  localparam logic [DENS_W-1:0] BAND_MODERATE_MAX  = 9'd150;

  typedef enum logic [CLASS_W-1:0] {
    AQ_CLEAN  = 3'd0,
    AQ_FAIR   = 3'd1,
    AQ_MILD   = 3'd2,
    AQ_POOR   = 3'd3,
    AQ_SEVERE = 3'd4
  } air_class_e;

  typedef struct packed {
    logic [ADC_W-1:0]  adc_sample;
    logic [TEMP_W-1:0] temperature;
  } in_t;

  typedef struct packed {
    logic [DENS_W-1:0] avg_density;
    logic [ADC_W-1:0]  avg_raw;
    air_class_e        air_class;
    logic              fan_on;
    logic [DUTY_W-1:0] fan_duty;
  } out_t;

endpackage

`default_nettype wire

[rtl/core/dust_density_average_and_fan_decision_unit.sv]
// ----------------------------------------------------------------------------
// dust_density_average_and_fan_decision_unit
// Converts dust sensor samples to densities, averages them over a group and
// emits air class and fan decision once per group.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake                      payload
//  --------  ---------  -----------------------------  ------------------
//  input     in         in_valid_i / in_stall_o        in_data_i  (in_t)
//  output    out        out_valid_o / out_stall_i      out_data_o (out_t)
//  config    in         cfg_we_i (no wait)             cfg_idx_i, cfg_wdata_i
//
// one transaction is taken per cycle while in_stall_o is low; three register
// stages (input, group, result) carry a group from its closing sample in the
// input register through the group register into the result register, which
// drives the output; each stage loads whenever it is empty or the stage after it moves, so
// input is stalled only when all three stages hold data and the output is
// stalled
// asynchronous active-low reset clears valids, the group counter, the sums
// and sets the configuration registers to their defaults
// ----------------------------------------------------------------------------
`default_nettype none

module dust_density_average_and_fan_decision_unit #(
  parameter int SAMPLES = ddfan_pkg::SAMPLES_DEF
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  // sample transactions
  input  wire logic                                in_valid_i,
  output logic                                     in_stall_o,
  input  wire ddfan_pkg::in_t                      in_data_i,
  // group results
  output logic                                     out_valid_o,
  input  wire logic                                out_stall_i,
  output ddfan_pkg::out_t                          out_data_o,
  // configuration writes
  input  wire logic                                cfg_we_i,
  input  wire logic [ddfan_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  wire logic [ddfan_pkg::CFG_DATA_W-1:0]    cfg_wdata_i
);

  import ddfan_pkg::*;

  // sizes that follow from the group length
  localparam int CNT_W  = $clog2(SAMPLES + 1);
  localparam int SUMD_W = $clog2(SAMPLES * DENS_MAX + 1);
  localparam int SUMR_W = $clog2(SAMPLES * ADC_MAX + 1);

  // sum / SAMPLES by a scaled reciprocal, exact over the sum range
  localparam int              AVGD_SHIFT = SUMD_W + $clog2(SAMPLES);
  localparam int              AVGR_SHIFT = SUMR_W + $clog2(SAMPLES);
  localparam longint unsigned AVGD_RECIP =
      ((64'd1 << AVGD_SHIFT) + 64'(SAMPLES) - 1) / 64'(SAMPLES);
  localparam longint unsigned AVGR_RECIP =
      ((64'd1 << AVGR_SHIFT) + 64'(SAMPLES) - 1) / 64'(SAMPLES);
  localparam int              AVGD_PROD_W = SUMD_W + AVGD_SHIFT + 1;
  localparam int              AVGR_PROD_W = SUMR_W + AVGR_SHIFT + 1;

  localparam logic [CNT_W-1:0] LAST_IDX = CNT_W'(SAMPLES - 1);

  // --------------------------------------------------------------------------
  // configuration registers
  // --------------------------------------------------------------------------
  logic [TLIM_W-1:0] temp_limit_q;
  logic [DLIM_W-1:0] dust_limit_q;
  logic [DUTY_W-1:0] fan_run_duty_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      temp_limit_q   <= TEMP_LIMIT_RST;
      dust_limit_q   <= DUST_LIMIT_RST;
      fan_run_duty_q <= FAN_RUN_DUTY_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_TEMP_LIMIT:   temp_limit_q   <= cfg_wdata_i[TLIM_W-1:0];
        CFG_DUST_LIMIT:   dust_limit_q   <= cfg_wdata_i[DLIM_W-1:0];
        CFG_FAN_RUN_DUTY: fan_run_duty_q <= cfg_wdata_i[DUTY_W-1:0];
        default: ;  // unmapped index, write dropped
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // stage flow control
  // --------------------------------------------------------------------------
  logic s1_valid_q, s2_valid_q, out_valid_q;
  logic out_en, s2_en, s1_en;

  assign out_en     = !out_valid_q || !out_stall_i;
  assign s2_en      = !s2_valid_q || out_en;
  assign s1_en      = !s1_valid_q || s2_en;
  assign in_stall_o = !s1_en;

  // --------------------------------------------------------------------------
  // stage 1: input register
  // --------------------------------------------------------------------------
  in_t s1_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_en) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_en && in_valid_i) begin
      s1_data_q <= in_data_i;
    end
  end

  // density of the registered sample
  logic [DENS_PROD_W-1:0] dens_prod;
  logic [DENS_W-1:0]      s1_density;

  always_comb begin
    dens_prod = DENS_PROD_W'(s1_data_q.adc_sample) * DENS_PROD_W'(DENS_MUL)
              - DENS_PROD_W'(DENS_SUB);
    if (s1_data_q.adc_sample <= ADC_W'(DENS_ZERO_ADC)) begin
      s1_density = '0;
    end else if (s1_data_q.adc_sample >= ADC_W'(DENS_SAT_ADC)) begin
      s1_density = DENS_W'(DENS_MAX);
    end else begin
      s1_density = dens_prod[DENS_SHIFT +: DENS_W];
    end
  end

  // --------------------------------------------------------------------------
  // group accumulation, final sums go to stage 2
  // --------------------------------------------------------------------------
  logic [CNT_W-1:0]  cnt_q;
  logic [SUMD_W-1:0] dsum_q, dsum_next;
  logic [SUMR_W-1:0] rsum_q, rsum_next;
  logic              s1_move, s1_last;

  assign s1_move   = s1_valid_q && s2_en;
  assign s1_last   = (cnt_q == LAST_IDX);
  assign dsum_next = dsum_q + SUMD_W'(s1_density);
  assign rsum_next = rsum_q + SUMR_W'(s1_data_q.adc_sample);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      dsum_q <= '0;
      rsum_q <= '0;
    end else if (s1_move) begin
      if (s1_last) begin
        cnt_q  <= '0;
        dsum_q <= '0;
        rsum_q <= '0;
      end else begin
        cnt_q  <= cnt_q + CNT_W'(1);
        dsum_q <= dsum_next;
        rsum_q <= rsum_next;
      end
    end
  end

  // stage 2: completed group
  logic [SUMD_W-1:0] s2_dsum_q;
  logic [SUMR_W-1:0] s2_rsum_q;
  logic [TEMP_W-1:0] s2_temp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (s2_en) begin
      s2_valid_q <= s1_valid_q && s1_last;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_move && s1_last) begin
      s2_dsum_q <= dsum_next;
      s2_rsum_q <= rsum_next;
      s2_temp_q <= s1_data_q.temperature;
    end
  end

  // --------------------------------------------------------------------------
  // stage 3: averages, band and fan decision into the result register
  // --------------------------------------------------------------------------
  logic [AVGD_PROD_W-1:0] avgd_prod;
  logic [AVGR_PROD_W-1:0] avgr_prod;
  out_t                   res;

  always_comb begin
    avgd_prod = AVGD_PROD_W'(s2_dsum_q) * AVGD_PROD_W'(AVGD_RECIP);
    avgr_prod = AVGR_PROD_W'(s2_rsum_q) * AVGR_PROD_W'(AVGR_RECIP);

    res.avg_density = avgd_prod[AVGD_SHIFT +: DENS_W];
    res.avg_raw     = avgr_prod[AVGR_SHIFT +: ADC_W];

    if (res.avg_density <= BAND_EXCELLENT_MAX) begin
      res.air_class = AQ_CLEAN;
    end else if (res.avg_density <= BAND_GOOD_MAX) begin
      res.air_class = AQ_FAIR;
    end else if (res.avg_density <= BAND_LIGHT_MAX) begin
      res.air_class = AQ_MILD;
    end else if (res.avg_density <= BAND_MODERATE_MAX) begin
      res.air_class = AQ_POOR;
    end else begin
      res.air_class = AQ_SEVERE;
    end

    // temperature of the group-closing sample or the average density
    res.fan_on   = (s2_temp_q >= TEMP_W'(temp_limit_q))
                || (res.avg_density >= dust_limit_q);
    res.fan_duty = res.fan_on ? fan_run_duty_q : '0;
  end

  out_t out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_en) begin
      out_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_en && s2_valid_q) begin
      out_data_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------

  // group counter stays below the group length
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= LAST_IDX)
  else $error("group counter out of range");

  // input is held back only when every stage is occupied
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (s1_valid_q && s2_valid_q && out_valid_q && out_stall_i))
  else $error("input stalled with a free stage");

  // average density never exceeds the clamp limit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.avg_density <= DENS_W'(DENS_MAX)))
  else $error("average density above limit");

  // duty is zero whenever the fan is off
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_data_o.fan_on) |-> (out_data_o.fan_duty == '0))
  else $error("duty given with fan off");

  // a finished group reaches the result register on the next move
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s2_valid_q && out_en) |=> out_valid_q)
  else $error("group result lost");

endmodule

`default_nettype wire

[tb/ddfan_checker.sv]
// ----------------------------------------------------------------------------
// ddfan_checker
// Watches the sample, result and configuration channels of the dust density
// unit, works out each group result on its own and compares every result
// transaction field by field against the oldest outstanding one.
// ----------------------------------------------------------------------------
`default_nettype none

module ddfan_checker #(
  parameter int SAMPLES = ddfan_pkg::SAMPLES_DEF
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             in_valid_i,
  input  wire logic                             in_stall_i,
  input  wire ddfan_pkg::in_t                   in_data_i,
  input  wire logic                             out_valid_i,
  input  wire logic                             out_stall_i,
  input  wire ddfan_pkg::out_t                  out_data_i,
  input  wire logic                             cfg_we_i,
  input  wire logic [ddfan_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [ddfan_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  output int                                    pending_o,
  output int                                    fail_count_o
);
  import ddfan_pkg::*;

  // shadow copies of the registers and the group accumulators
  logic [TLIM_W-1:0] temp_limit;
  logic [DLIM_W-1:0] dust_limit;
  logic [DUTY_W-1:0] run_duty;
  int unsigned       samples_taken;
  int unsigned       density_acc;
  int unsigned       raw_acc;

  out_t group_results_q[$];
  int   mismatches = 0;

  assign fail_count_o = mismatches;

  // clamp to 0..500, then round half up
  function automatic logic [DENS_W-1:0] sample_density(input logic [ADC_W-1:0] adc);
    longint unsigned scaled;
    longint unsigned excess;
    scaled = DENS_SCALE * adc;
    if (scaled <= DENS_OFFSET) return '0;
    excess = scaled - DENS_OFFSET;
    if (excess >= DENS_MAX * DENS_DEN) return DENS_W'(DENS_MAX);
    return DENS_W'((2 * excess + DENS_DEN) / (2 * DENS_DEN));
  endfunction

  function automatic air_class_e quality_band(input logic [DENS_W-1:0] density);
    if (density <= BAND_EXCELLENT_MAX) return AQ_CLEAN;
    if (density <= BAND_GOOD_MAX)      return AQ_FAIR;
    if (density <= BAND_LIGHT_MAX)     return AQ_MILD;
    if (density <= BAND_MODERATE_MAX)  return AQ_POOR;
    return AQ_SEVERE;
  endfunction

  task automatic report_mismatch(input string msg);
    mismatches++;
    $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    out_t              want;
    out_t              got;
    logic [DENS_W-1:0] avg_density;
    logic              fan;
    if (!rst_ni) begin
      temp_limit    = TEMP_LIMIT_RST;
      dust_limit    = DUST_LIMIT_RST;
      run_duty      = FAN_RUN_DUTY_RST;
      samples_taken = 0;
      density_acc   = 0;
      raw_acc       = 0;
      group_results_q.delete();
      pending_o <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        got = out_data_i;
        if (group_results_q.size() == 0) begin
          report_mismatch($sformatf("result with no group outstanding: %p", got));
        end else begin
          want = group_results_q.pop_front();
          if (got.avg_density !== want.avg_density)
            report_mismatch($sformatf("avg_density %0d, want %0d",
                                      got.avg_density, want.avg_density));
          if (got.avg_raw !== want.avg_raw)
            report_mismatch($sformatf("avg_raw %0d, want %0d", got.avg_raw, want.avg_raw));
          if (got.air_class !== want.air_class)
            report_mismatch($sformatf("air_class %0d, want %0d",
                                      got.air_class, want.air_class));
          if (got.fan_on !== want.fan_on)
            report_mismatch($sformatf("fan_on %0b, want %0b", got.fan_on, want.fan_on));
          if (got.fan_duty !== want.fan_duty)
            report_mismatch($sformatf("fan_duty %0d, want %0d", got.fan_duty, want.fan_duty));
        end
      end
      if (in_valid_i && !in_stall_i) begin
        density_acc += sample_density(in_data_i.adc_sample);
        raw_acc     += in_data_i.adc_sample;
        samples_taken++;
        if (samples_taken == SAMPLES) begin
          avg_density = DENS_W'(density_acc / SAMPLES);
          // only the temperature of the closing sample counts
          fan = (in_data_i.temperature >= temp_limit) || (avg_density >= dust_limit);
          want.avg_density = avg_density;
          want.avg_raw     = ADC_W'(raw_acc / SAMPLES);
          want.air_class   = quality_band(avg_density);
          want.fan_on      = fan;
          want.fan_duty    = fan ? run_duty : '0;
          group_results_q.push_back(want);
          samples_taken = 0;
          density_acc   = 0;
          raw_acc       = 0;
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_TEMP_LIMIT:   temp_limit = cfg_wdata_i[TLIM_W-1:0];
          CFG_DUST_LIMIT:   dust_limit = cfg_wdata_i[DLIM_W-1:0];
          CFG_FAN_RUN_DUTY: run_duty   = cfg_wdata_i[DUTY_W-1:0];
          default: ;
        endcase
      end
      pending_o <= group_results_q.size();
    end
  end

endmodule

`default_nettype wire

[tb/dust_density_average_and_fan_decision_unit_tb.sv]
// ----------------------------------------------------------------------------
// dust_density_average_and_fan_decision_unit_tb
// Drives sample transactions and register writes into the dust density unit
// and lets a checker beside it predict and compare every group result. A
// short directed run covers the corners, then random phases sweep the
// register settings under changing sender and receiver pressure.
// ----------------------------------------------------------------------------
`default_nettype none

module dust_density_average_and_fan_decision_unit_tb;
  import ddfan_pkg::*;

  localparam int SAMPLES      = SAMPLES_DEF;
  localparam int PHASES       = 8;
  // pipeline is three stages deep, leave some margin before a register write
  localparam int DRAIN_CYCLES = 8;
  localparam int CYCLE_LIMIT  = 200000;

  // an index with no register behind it, writes there must be ignored
  localparam logic [CFG_IDX_W-1:0] CFG_NO_REG = 2'd3;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  in_t                   in_data;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_t                  out_data;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  int pending;
  int fail_count;
  int cycle_count    = 0;
  int send_idle_pct  = 22;
  int recv_stall_pct = 57;

  // 12 unit clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  dust_density_average_and_fan_decision_unit #(
    .SAMPLES (SAMPLES)
  ) dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  ddfan_checker #(
    .SAMPLES (SAMPLES)
  ) checker_i (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .in_data_i    (in_data),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .out_data_i   (out_data),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_wdata_i  (cfg_wdata),
    .pending_o    (pending),
    .fail_count_o (fail_count)
  );

  // receiver back-pressure, redrawn every cycle
  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("** dust_density_average_and_fan_decision_unit: FAILED **");
      $finish;
    end
  end

  // one sample transaction, with random idle cycles ahead of it
  // the payload holds steady until the unit takes it
  task automatic send_sample(input logic [ADC_W-1:0] adc, input logic [TEMP_W-1:0] temp);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{adc_sample: adc, temperature: temp};
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // hold off the sender until every outstanding group result is out,
  // then give a partial group in flight time to settle
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    int          n_items;
    int          base;
    int          adc_val;
    logic        shaped;
    logic [7:0]  temp;

    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_we    <= 1'b0;
    cfg_idx   <= CFG_TEMP_LIMIT;
    cfg_wdata <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed groups at the reset settings (temp 25, dust 100, duty 500)
    // all zero samples, fan from temperature alone on the closing sample
    send_sample(12'd0, 8'd0);
    send_sample(12'd0, 8'd255);
    send_sample(12'd0, 8'd0);
    send_sample(12'd0, 8'd0);
    send_sample(12'd0, 8'd255);
    // full scale, density saturates, heavy band, fan from dust alone
    send_sample(12'hFFF, 8'd255);
    send_sample(12'hFFF, 8'd255);
    send_sample(12'hFFF, 8'd255);
    send_sample(12'hFFF, 8'd255);
    send_sample(12'hFFF, 8'd0);
    // around the zero and saturation knees, temperature one below its limit
    send_sample(12'(DENS_ZERO_ADC), 8'hAA);
    send_sample(12'(DENS_ZERO_ADC + 1), 8'h55);
    send_sample(12'(DENS_SAT_ADC - 1), 8'hAA);
    send_sample(12'(DENS_SAT_ADC), 8'h55);
    send_sample(12'hAAA, 8'd24);
    // alternating bit patterns, temperature exactly at its limit
    send_sample(12'h555, 8'hF0);
    send_sample(12'hAAA, 8'h0F);
    send_sample(12'h555, 8'h80);
    send_sample(12'h800, 8'h7F);
    send_sample(12'h7FF, 8'd25);
    // average density landing exactly on the dust limit
    repeat (4) send_sample(12'd730, 8'd0);
    send_sample(12'd730, 8'd0);
    drain_results();

    for (int phase = 0; phase < PHASES; phase++) begin
      // registers change only with nothing in flight
      case (phase)
        0: begin
          // lowest raw values: a dust limit of zero keeps the fan on
          write_reg(CFG_TEMP_LIMIT, 16'd0);
          write_reg(CFG_DUST_LIMIT, 16'd0);
          write_reg(CFG_FAN_RUN_DUTY, 16'hFFFF);
        end
        1: begin
          // all ones, only the register width survives
          write_reg(CFG_TEMP_LIMIT, 16'hFFFF);
          write_reg(CFG_DUST_LIMIT, 16'hFFFF);
          write_reg(CFG_FAN_RUN_DUTY, 16'd0);
        end
        2: begin
          write_reg(CFG_TEMP_LIMIT, 16'd20);
          write_reg(CFG_DUST_LIMIT, 16'd50);
          write_reg(CFG_FAN_RUN_DUTY, 16'($urandom_range(0, 65535)));
        end
        3: begin
          write_reg(CFG_TEMP_LIMIT, 16'd50);
          write_reg(CFG_DUST_LIMIT, 16'd300);
          write_reg(CFG_FAN_RUN_DUTY, 16'($urandom_range(0, 65535)));
        end
        PHASES - 1: begin
          // arbitrary raw data on every register
          write_reg(CFG_TEMP_LIMIT, 16'($urandom));
          write_reg(CFG_DUST_LIMIT, 16'($urandom));
          write_reg(CFG_FAN_RUN_DUTY, 16'($urandom));
        end
        default: begin
          write_reg(CFG_TEMP_LIMIT, 16'($urandom_range(20, 50)));
          write_reg(CFG_NO_REG, 16'($urandom));
          write_reg(CFG_DUST_LIMIT, 16'($urandom_range(50, 300)));
          write_reg(CFG_FAN_RUN_DUTY, 16'($urandom));
        end
      endcase

      // sender light and receiver heavy, then swapped, then free running
      if (phase < 3) begin
        send_idle_pct  = 22;
        recv_stall_pct = 57;
      end else if (phase < 6) begin
        send_idle_pct  = 57;
        recv_stall_pct = 22;
      end else begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
      end

      // phase length is drawn from 150 to 159 and is often not a multiple of the
      // group size, so register writes also land in the middle of a group
      n_items = 150 + $urandom_range(0, 9);
      for (int k = 0; k < n_items; k++) begin
        // mostly clustered groups around a density of interest, some noise
        if (k % SAMPLES == 0) begin
          shaped = ($urandom_range(0, 9) < 7);
          base   = $urandom_range(0, 3) == 0 ? $urandom_range(0, 4095)
                                             : $urandom_range(300, 2300);
        end
        if (shaped) begin
          adc_val = base + $urandom_range(0, 30) - 15;
          if (adc_val < 0) adc_val = 0;
          if (adc_val > ADC_MAX) adc_val = ADC_MAX;
        end else begin
          adc_val = $urandom_range(0, ADC_MAX);
        end
        // keep many temperatures near the limits in use
        temp = ($urandom_range(0, 2) == 0) ? 8'($urandom_range(15, 65))
                                           : 8'($urandom_range(0, 255));
        send_sample(12'(adc_val), temp);
        if ($urandom_range(0, 199) == 0) drain_results();
      end
      drain_results();
    end

    if (fail_count == 0) begin
      $display("** dust_density_average_and_fan_decision_unit: PASSED **");
    end else begin
      $display("** dust_density_average_and_fan_decision_unit: FAILED **");
    end
    $finish;
  end

endmodule

`default_nettype wire
